// ----- rtl/hrkm_pkg.sv -----
// Shared types, constants and the scancode map for the HID report to key matrix block.
// No dependencies.
package hrkm_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int KEY_SLOTS_MAX = 6;
  localparam int ROWS          = 8;
  localparam int ROW_W         = 8;
  localparam int ROW_SEL_W     = 3;
  localparam int MATRIX_W      = ROWS * ROW_W;
  localparam int CODE_W        = 8;
  localparam int ENTRY_W       = ROW_SEL_W + ROW_W;
  localparam int IN_DATA_W     = CODE_W * (1 + KEY_SLOTS_MAX);
  localparam int OUT_DATA_W    = MATRIX_W + 8;

  // control-key byte bits
  localparam logic [7:0] CF_VVOD   = 8'h01;
  localparam logic [7:0] CF_SBROS  = 8'h02;
  localparam logic [7:0] CF_OSD    = 8'h04;
  localparam logic [7:0] CF_PAUSE  = 8'h08;
  localparam logic [7:0] CF_SHIFT  = 8'h20;
  localparam logic [7:0] CF_CTRL   = 8'h40;
  localparam logic [7:0] CF_RUSLAT = 8'h80;

  // modifier byte masks
  localparam logic [7:0] MOD_CTRL  = 8'h11;
  localparam logic [7:0] MOD_SHIFT = 8'h22;
  localparam logic [7:0] MOD_LGUI  = 8'h08;
  localparam logic [7:0] MOD_RALT  = 8'h40;

  // scancodes that set control bits instead of matrix bits; SC_RALT sets a matrix bit
  localparam logic [7:0] SC_F6     = 8'h3F;
  localparam logic [7:0] SC_F11    = 8'h44;
  localparam logic [7:0] SC_F12    = 8'h45;
  localparam logic [7:0] SC_SCROLL = 8'h47;
  localparam logic [7:0] SC_PAUSE  = 8'h48;
  localparam logic [7:0] SC_RALT   = 8'hE6;

  typedef struct packed {
    logic [MATRIX_W-1:0] rows;
    logic [7:0]          ctl;
  } lane_res_t;

  // entry: row in [10:8], bit mask in [7:0]; zero means unmapped
  function automatic logic [ENTRY_W-1:0] scan_lookup(input logic [CODE_W-1:0] code);
    logic [ENTRY_W-1:0] e;
    case (code)
      8'h2C: e = 11'h780;  8'h35: e = 11'h740;  8'h30: e = 11'h720;  8'h31: e = 11'h710;
      8'h2F: e = 11'h708;  8'h1D: e = 11'h704;  8'h1C: e = 11'h702;  8'h1B: e = 11'h701;
      8'h1A: e = 11'h680;  8'h19: e = 11'h640;  8'h18: e = 11'h620;  8'h17: e = 11'h610;
      8'h16: e = 11'h608;  8'h15: e = 11'h604;  8'h14: e = 11'h602;  8'h13: e = 11'h601;
      8'h12: e = 11'h580;  8'h11: e = 11'h540;  8'h10: e = 11'h520;  8'h0F: e = 11'h510;
      8'h0E: e = 11'h508;  8'h0D: e = 11'h504;  8'h0C: e = 11'h502;  8'h0B: e = 11'h501;
      8'h0A: e = 11'h480;  8'h09: e = 11'h440;  8'h08: e = 11'h420;  8'h07: e = 11'h410;
      8'h06: e = 11'h408;  8'h05: e = 11'h404;  8'h04: e = 11'h402;  8'h2D: e = 11'h401;
      8'h38: e = 11'h380;  8'h37: e = 11'h340;  8'h2E: e = 11'h320;  8'h36: e = 11'h310;
      8'h33: e = 11'h308;  8'h34: e = 11'h304;  8'h26: e = 11'h302;  8'h25: e = 11'h301;
      8'h24: e = 11'h280;  8'h23: e = 11'h240;  8'h22: e = 11'h220;  8'h21: e = 11'h210;
      8'h20: e = 11'h208;  8'h1F: e = 11'h204;  8'h1E: e = 11'h202;  8'h27: e = 11'h201;
      8'h3E: e = 11'h180;  8'h3D: e = 11'h140;  8'h3C: e = 11'h120;  8'h3B: e = 11'h110;
      8'h3A: e = 11'h108;  8'h29: e = 11'h104;  8'h4D: e = 11'h102;  8'h4A: e = 11'h101;
      8'h51: e = 11'h080;  8'h4F: e = 11'h040;  8'h52: e = 11'h020;  8'h50: e = 11'h010;
      8'h2A: e = 11'h008;  8'h28: e = 11'h004;  8'hE6: e = 11'h002;  8'h2B: e = 11'h001;
      default: e = '0;
    endcase
    return e;
  endfunction

  // spread a map entry into its place in the 64-bit matrix
  function automatic logic [MATRIX_W-1:0] entry_to_matrix(input logic [ENTRY_W-1:0] e);
    logic [MATRIX_W-1:0] m;
    m = '0;
    m[e[ENTRY_W-1:ROW_W]*ROW_W +: ROW_W] = e[ROW_W-1:0];
    return m;
  endfunction

endpackage

// ----- rtl/hrkm_lane.sv -----
// One decode lane: turns a single scancode into matrix bits and control bits.
// Depends on hrkm_pkg.
module hrkm_lane
  import hrkm_pkg::*;
(
  input  logic [CODE_W-1:0] code,
  output lane_res_t         res
);

  always_comb begin
    res.rows = '0;
    res.ctl  = '0;
    case (code)
      SC_F6:     res.ctl = CF_RUSLAT;
      SC_F11:    res.ctl = CF_VVOD;
      SC_F12:    res.ctl = CF_SBROS;
      SC_SCROLL: res.ctl = CF_OSD;
      SC_PAUSE:  res.ctl = CF_PAUSE;
      default:   res.rows = entry_to_matrix(scan_lookup(code));
    endcase
  end

endmodule

// ----- rtl/hrkm_merge.sv -----
// Merge stage: ORs lane results with the modifier bits and holds the result register.
// Depends on hrkm_pkg.
module hrkm_merge
  import hrkm_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [7:0]                 modifiers,
  input  lane_res_t [KEY_SLOTS-1:0]  lanes,
  input  logic                       take,
  output logic                       valid,
  output logic [OUT_DATA_W-1:0]      result
);

  logic [MATRIX_W-1:0] rows_next;
  logic [7:0]          ctl_next;

  always_comb begin
    rows_next = '0;
    ctl_next  = '0;
    if ((modifiers & MOD_CTRL) != '0)  ctl_next = ctl_next | CF_CTRL;
    if ((modifiers & MOD_SHIFT) != '0) ctl_next = ctl_next | CF_SHIFT;
    if ((modifiers & MOD_LGUI) != '0)  ctl_next = ctl_next | CF_RUSLAT;
    // right Alt acts as the PS key
    if ((modifiers & MOD_RALT) != '0)  rows_next = entry_to_matrix(scan_lookup(SC_RALT));
    for (int i = 0; i < KEY_SLOTS; i++) begin
      rows_next = rows_next | lanes[i].rows;
      ctl_next  = ctl_next | lanes[i].ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= {ctl_next, rows_next};
    end
  end

endmodule

// ----- rtl/hrkm_top.sv -----
// HID boot report to retro key matrix converter, top level.
// Depends on hrkm_pkg, hrkm_lane and hrkm_merge.
//
// Usage:
//   Input stream s_axis_*: one transfer carries one HID boot keyboard report.
//   Output stream m_axis_*: one transfer carries the 8x8 key matrix and the
//   control-key byte built from that report. Every report yields exactly one
//   result; nothing is carried from one report to the next.
//
// Data path:
//   An accepted report is registered in the single result register and is on
//   m_axis_tdata in the next cycle. One report per cycle is sustained while the
//   receiver takes each result: KEY_SLOTS decode lanes look up the first
//   KEY_SLOTS scancodes at once and the merge stage ORs them in the same cycle,
//   so the result register is the only storage in the path.
//
// Reset (rst, synchronous, active high) empties the result register; no other
// state exists. When the receiver stalls, the held result stays put and
// s_axis_tready drops until that result is taken; a new report can be taken
// in the same cycle the held one leaves.
module hid_report_to_key_matrix_top
  import hrkm_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] modifiers, [15:8] key0, [23:16] key1, [31:24] key2,
  // [39:32] key3, [47:40] key4, [55:48] key5
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] row0 ... [63:56] row7, [71:64] control_flags
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  lane_res_t [KEY_SLOTS-1:0] lanes;
  logic                      load;

  // slots at or beyond KEY_SLOTS get no lane and are ignored
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hrkm_lane u_lane (
      .code (s_axis_tdata[(g+1)*CODE_W +: CODE_W]),
      .res  (lanes[g])
    );
  end

  // result register frees up when empty or when its transfer completes
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign load          = s_axis_tvalid && s_axis_tready;

  hrkm_merge #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .modifiers (s_axis_tdata[CODE_W-1:0]),
    .lanes     (lanes),
    .take      (m_axis_tready),
    .valid     (m_axis_tvalid),
    .result    (m_axis_tdata)
  );

endmodule
